// ----- hw/rtl/hfw_pkg.sv -----
`timescale 1ns / 1ps

package hfw_pkg;

   localparam int unsigned BUCKET_COUNT_DEF    = 256;
   localparam int unsigned WAYS_PER_BUCKET_DEF = 4;

   localparam logic [31:0] MIX_MUL_A   = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B   = 32'h846ca68b;
   localparam int unsigned MIX_SHIFT_A = 16;
   localparam int unsigned MIX_SHIFT_B = 15;
   localparam int unsigned MIX_SHIFT_C = 16;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] dest_addr;
      logic [15:0] dest_port;
      logic [7:0]  protocol;
   } req_type;

   typedef struct packed {
      logic matched;
      logic status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] dest_addr;
      logic [15:0] dest_port;
      logic [7:0]  protocol;
   } key_type;

   typedef struct packed {
      logic rd_en;
      logic valid_we;
      logic key_we;
   } tbl_cmd_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MIX,
      ST_MOD_Q,
      ST_MOD_R,
      ST_MOD_FIX,
      ST_READ,
      ST_CHECK
   } state_type;

endpackage

// ----- hw/rtl/hashed_flow_whitelist.sv -----
`timescale 1ns / 1ps

// channel  ports                          item
// req      req_valid req_ready req_data   hfw_pkg::req_type (operation, addr, port, protocol)
// rsp      rsp_valid rsp_ready rsp_data   hfw_pkg::rsp_type (matched, status)
//
// Insert, lookup, unused code: MUL_A, MUL_B, MIX, READ, CHECK; if BUCKET_COUNT is no power of
// two, MOD_Q, MOD_R, MOD_FIX follow MIX (reciprocal and back multiply, one correcting subtract).
// Hash uses one shared 32x32 multiplier; bucket row is read in one memory access.
// Clear: valid row sweep over every row, result after the last row. Reset starts the same
// sweep with no result, req_ready low until it ends.
// Next item can be accepted in the cycle after its result is registered, even while that result
// waits; a stalled result holds the block in its final step.

module hashed_flow_whitelist #(
   parameter int unsigned BUCKET_COUNT    = hfw_pkg::BUCKET_COUNT_DEF,
   parameter int unsigned WAYS_PER_BUCKET = hfw_pkg::WAYS_PER_BUCKET_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hfw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hfw_pkg::rsp_type rsp_data
);

   localparam int unsigned ROW_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam bit          BC_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);
   localparam logic [ROW_W:0]   BC_VAL    = (ROW_W + 1)'(BUCKET_COUNT);
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(BUCKET_COUNT - 1);
   localparam logic [31:0]      BC_WORD   = 32'(BUCKET_COUNT);
   localparam logic [31:0]      MOD_RECIP = 32'((64'd1 << 32) / 64'(BUCKET_COUNT));

   hfw_pkg::state_type state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   hfw_pkg::key_type   key_ff, key_in;
   logic [31:0]        x_ff, x_in;
   logic [31:0]        q_ff, q_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ROW_W:0]     rem_ff, rem_in;
   logic               sweep_rsp_ff, sweep_rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   hfw_pkg::rsp_type   rsp_ff, rsp_in;

   logic [31:0]        x_pre;
   logic [31:0]        mul_a, mul_b, mul_lo;
   logic [63:0]        mul_full;
   logic [31:0]        hash;
   logic [31:0]        x_diff;
   logic [ROW_W:0]     rem_nx;
   logic               out_free;

   hfw_pkg::tbl_cmd_type                   tbl_cmd;
   logic [WAYS_PER_BUCKET-1:0]             wr_valid_row;
   logic [WAYS_PER_BUCKET-1:0]             rd_valid_row;
   hfw_pkg::key_type [WAYS_PER_BUCKET-1:0] rd_key_row;
   logic [WAYS_PER_BUCKET-1:0]             free_row, free_oh;
   logic                                   bucket_full, hit;

   hfw_table #(
      .BUCKET_COUNT    (BUCKET_COUNT),
      .WAYS_PER_BUCKET (WAYS_PER_BUCKET),
      .ROW_W           (ROW_W)
   ) u_table (
      .clock        (clock),
      .cmd          (tbl_cmd),
      .row          (row_ff),
      .wr_valid_row (wr_valid_row),
      .wr_way_oh    (free_oh),
      .wr_key       (key_ff),
      .rd_valid_row (rd_valid_row),
      .rd_key_row   (rd_key_row)
   );

   // premix of the incoming key
   always_comb begin
      x_pre = req_data.dest_addr ^ {req_data.dest_port, 16'h0000} ^ {24'h000000, req_data.protocol};
      x_pre = x_pre ^ (x_pre >> hfw_pkg::MIX_SHIFT_A);
   end

   // shared multiplier
   always_comb begin
      mul_a = x_ff;
      mul_b = hfw_pkg::MIX_MUL_A;
      case (state_ff)
         hfw_pkg::ST_MUL_B: begin
            mul_a = x_ff ^ (x_ff >> hfw_pkg::MIX_SHIFT_B);
            mul_b = hfw_pkg::MIX_MUL_B;
         end
         hfw_pkg::ST_MOD_Q: begin
            mul_b = MOD_RECIP;
         end
         hfw_pkg::ST_MOD_R: begin
            mul_a = q_ff;
            mul_b = BC_WORD;
         end
         default: begin
         end
      endcase
   end

   assign mul_full = 64'(mul_a) * 64'(mul_b);
   assign mul_lo   = mul_full[31:0];
   assign hash     = x_ff ^ (x_ff >> hfw_pkg::MIX_SHIFT_C);

   // remainder: quotient estimate is low by at most one
   assign x_diff = x_ff - mul_lo;
   assign rem_nx = (rem_ff >= BC_VAL) ? (rem_ff - BC_VAL) : rem_ff;

   // bucket row check
   always_comb begin
      free_row    = ~rd_valid_row;
      free_oh     = free_row & (~free_row + WAYS_PER_BUCKET'(1));
      bucket_full = (free_row == '0);
      hit         = 1'b0;
      for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
         if (rd_valid_row[w] && rd_key_row[w].dest_addr == key_ff.dest_addr &&
             rd_key_row[w].dest_port == key_ff.dest_port &&
             (rd_key_row[w].protocol == 8'h00 || rd_key_row[w].protocol == key_ff.protocol)) begin
            hit = 1'b1;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      row_in       = row_ff;
      rem_in       = rem_ff;
      sweep_rsp_in = sweep_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      tbl_cmd      = '0;
      wr_valid_row = '0;

      case (state_ff)
         hfw_pkg::ST_SWEEP: begin
            tbl_cmd.valid_we = 1'b1;
            if (row_ff == LAST_ROW) begin
               if (!sweep_rsp_ff) begin
                  state_in = hfw_pkg::ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  state_in     = hfw_pkg::ST_IDLE;
               end
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         hfw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = req_data.operation;
               key_in = '{dest_addr: req_data.dest_addr, dest_port: req_data.dest_port,
                          protocol: req_data.protocol};
               x_in   = x_pre;
               if (req_data.operation == hfw_pkg::OP_CLEAR) begin
                  row_in       = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = hfw_pkg::ST_SWEEP;
               end else begin
                  state_in = hfw_pkg::ST_MUL_A;
               end
            end
         end
         hfw_pkg::ST_MUL_A: begin
            x_in     = mul_lo;
            state_in = hfw_pkg::ST_MUL_B;
         end
         hfw_pkg::ST_MUL_B: begin
            x_in     = mul_lo;
            state_in = hfw_pkg::ST_MIX;
         end
         hfw_pkg::ST_MIX: begin
            if (BC_POW2) begin
               row_in   = hash[ROW_W-1:0];
               state_in = hfw_pkg::ST_READ;
            end else begin
               x_in     = hash;
               state_in = hfw_pkg::ST_MOD_Q;
            end
         end
         hfw_pkg::ST_MOD_Q: begin
            q_in     = mul_full[63:32];
            state_in = hfw_pkg::ST_MOD_R;
         end
         hfw_pkg::ST_MOD_R: begin
            rem_in   = x_diff[ROW_W:0];
            state_in = hfw_pkg::ST_MOD_FIX;
         end
         hfw_pkg::ST_MOD_FIX: begin
            row_in   = rem_nx[ROW_W-1:0];
            state_in = hfw_pkg::ST_READ;
         end
         hfw_pkg::ST_READ: begin
            tbl_cmd.rd_en = 1'b1;
            state_in      = hfw_pkg::ST_CHECK;
         end
         hfw_pkg::ST_CHECK: begin
            wr_valid_row = rd_valid_row | free_oh;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (op_ff == hfw_pkg::OP_INSERT) begin
                  rsp_in.status    = bucket_full;
                  tbl_cmd.valid_we = !bucket_full;
                  tbl_cmd.key_we   = !bucket_full;
               end else if (op_ff == hfw_pkg::OP_LOOKUP) begin
                  rsp_in.matched = hit;
               end
               state_in = hfw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hfw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hfw_pkg::ST_SWEEP;
         row_ff       <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      x_ff   <= x_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted on back-to-back cycles");

   a_insert_one_way: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hfw_pkg::ST_CHECK && tbl_cmd.valid_we) |->
      $onehot(wr_valid_row ^ rd_valid_row))
      else $error("insert must set exactly one free way");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.matched && rsp_ff.status))
      else $error("matched and status both set");

   a_reset_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hfw_pkg::ST_SWEEP && !sweep_rsp_ff) |-> !rsp_valid_ff)
      else $error("result pending during reset sweep");

endmodule

// ----- hw/rtl/hfw_table.sv -----
`timescale 1ns / 1ps

module hfw_table #(
   parameter int unsigned BUCKET_COUNT    = hfw_pkg::BUCKET_COUNT_DEF,
   parameter int unsigned WAYS_PER_BUCKET = hfw_pkg::WAYS_PER_BUCKET_DEF,
   parameter int unsigned ROW_W           = 8
) (
   input  logic                                        clock,
   input  hfw_pkg::tbl_cmd_type                        cmd,
   input  logic [ROW_W-1:0]                            row,
   input  logic [WAYS_PER_BUCKET-1:0]                  wr_valid_row,
   input  logic [WAYS_PER_BUCKET-1:0]                  wr_way_oh,
   input  hfw_pkg::key_type                            wr_key,
   output logic [WAYS_PER_BUCKET-1:0]                  rd_valid_row,
   output hfw_pkg::key_type [WAYS_PER_BUCKET-1:0]      rd_key_row
);

   logic [WAYS_PER_BUCKET-1:0]             valid_mem [BUCKET_COUNT];
   hfw_pkg::key_type [WAYS_PER_BUCKET-1:0] key_mem   [BUCKET_COUNT];

   logic [WAYS_PER_BUCKET-1:0]             rd_valid_row_ff;
   hfw_pkg::key_type [WAYS_PER_BUCKET-1:0] rd_key_row_ff;

   always_ff @(posedge clock) begin
      if (cmd.valid_we) begin
         valid_mem[row] <= wr_valid_row;
      end
      if (cmd.rd_en) begin
         rd_valid_row_ff <= valid_mem[row];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_we) begin
         for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            if (wr_way_oh[w]) begin
               key_mem[row][w] <= wr_key;
            end
         end
      end
      if (cmd.rd_en) begin
         rd_key_row_ff <= key_mem[row];
      end
   end

   assign rd_valid_row = rd_valid_row_ff;
   assign rd_key_row   = rd_key_row_ff;

endmodule

// ----- dv/hashed_flow_whitelist_tb.sv -----
`timescale 1ns / 1ps

module hashed_flow_whitelist_tb;

   localparam int unsigned BUCKETS      = hfw_pkg::BUCKET_COUNT_DEF;
   localparam int unsigned WAYS         = hfw_pkg::WAYS_PER_BUCKET_DEF;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned STALL_CYCLES = 300;
   localparam int unsigned TAIL_CYCLES  = 60;
   localparam int unsigned POOL_DEPTH   = 16;

   class allow_list_tracker;
      bit               live [BUCKETS*WAYS];
      hfw_pkg::key_type stored [BUCKETS*WAYS];
      hfw_pkg::rsp_type verdict_q [$];
      int unsigned      errors;

      static function int unsigned bucket_of(hfw_pkg::key_type k);
         logic [31:0] x;
         x = k.dest_addr ^ {k.dest_port, 16'h0000} ^ {24'h000000, k.protocol};
         x = x ^ (x >> hfw_pkg::MIX_SHIFT_A);
         x = x * hfw_pkg::MIX_MUL_A;
         x = x ^ (x >> hfw_pkg::MIX_SHIFT_B);
         x = x * hfw_pkg::MIX_MUL_B;
         x = x ^ (x >> hfw_pkg::MIX_SHIFT_C);
         return x % BUCKETS;
      endfunction

      function void apply_request(hfw_pkg::req_type r);
         hfw_pkg::rsp_type v;
         hfw_pkg::key_type k;
         int unsigned      base;
         bit               placed;
         v = '0;
         k = {r.dest_addr, r.dest_port, r.protocol};
         base = bucket_of(k) * WAYS;
         placed = 1'b0;
         case (r.operation)
            hfw_pkg::OP_CLEAR: begin
               foreach (live[i]) live[i] = 1'b0;
            end
            hfw_pkg::OP_INSERT: begin
               for (int w = 0; w < WAYS && !placed; w++) begin
                  if (!live[base + w]) begin
                     live[base + w]   = 1'b1;
                     stored[base + w] = k;
                     placed           = 1'b1;
                  end
               end
               v.status = !placed;
            end
            hfw_pkg::OP_LOOKUP: begin
               for (int w = 0; w < WAYS; w++) begin
                  if (live[base + w] && stored[base + w].dest_addr == k.dest_addr &&
                      stored[base + w].dest_port == k.dest_port &&
                      (stored[base + w].protocol == 8'h00 ||
                       stored[base + w].protocol == k.protocol)) begin
                     v.matched = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         verdict_q.push_back(v);
      endfunction

      function void compare_verdict(hfw_pkg::rsp_type got);
         hfw_pkg::rsp_type want;
         if (verdict_q.size() == 0) begin
            $error("result item with no expectation waiting: matched %0d status %0d",
                   got.matched, got.status);
            errors++;
            return;
         end
         want = verdict_q.pop_front();
         if (got.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, got.matched);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   hfw_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   hfw_pkg::rsp_type rsp_data;

   allow_list_tracker table_model;
   hfw_pkg::key_type  known_keys [$];
   bit                idling_on;
   bit                stall_request = 1'b0;
   bit                stall_done = 1'b0;
   int unsigned       stall_left = 0;
   int unsigned       cycles = 0;

   hashed_flow_whitelist dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("hashed_flow_whitelist regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_request && !stall_done) begin
         stall_done = 1'b1;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idling_on && $urandom_range(99, 0) < 12);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) table_model.compare_verdict(rsp_data);
   end

   // protocol other than 0 whose key lands in the same bucket as the wildcard key
   function automatic bit find_twin(input hfw_pkg::key_type k, output logic [7:0] twin);
      int unsigned      home;
      hfw_pkg::key_type probe;
      probe          = k;
      probe.protocol = 8'h00;
      home           = allow_list_tracker::bucket_of(probe);
      for (int p = 1; p < 256; p++) begin
         probe.protocol = p[7:0];
         if (allow_list_tracker::bucket_of(probe) == home) begin
            twin = p[7:0];
            return 1'b1;
         end
      end
      twin = 8'h00;
      return 1'b0;
   endfunction

   task automatic send_item(input logic [1:0] op, input hfw_pkg::key_type k);
      hfw_pkg::req_type item;
      item.operation = op;
      item.dest_addr = k.dest_addr;
      item.dest_port = k.dest_port;
      item.protocol  = k.protocol;
      if (idling_on && $urandom_range(99, 0) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      table_model.apply_request(item);
      @(negedge clock);
   endtask

   task automatic random_item();
      int unsigned      roll;
      int unsigned      sub;
      int unsigned      pick;
      hfw_pkg::key_type k;
      logic [7:0]       twin;
      roll        = $urandom_range(99, 0);
      sub         = $urandom_range(99, 0);
      k.dest_addr = $urandom;
      k.dest_port = 16'($urandom_range(65535, 0));
      k.protocol  = 8'($urandom_range(255, 0));
      pick        = (known_keys.size() > 0) ? $urandom_range(known_keys.size() - 1, 0) : 0;
      if (roll < 2) begin
         known_keys.delete();
         send_item(hfw_pkg::OP_CLEAR, k);
      end else if (roll < 4) begin
         send_item(OP_UNUSED, k);
      end else if (roll < 40) begin
         if (sub < 45 && known_keys.size() > 0) begin
            k = known_keys[pick];
         end else begin
            if (sub < 65) k.protocol = 8'h00;
            known_keys.push_back(k);
            if (known_keys.size() > POOL_DEPTH) void'(known_keys.pop_front());
         end
         send_item(hfw_pkg::OP_INSERT, k);
      end else begin
         if (sub < 80 && known_keys.size() > 0) begin
            k = known_keys[pick];
            if (sub >= 50 && sub < 65) begin
               if (k.protocol == 8'h00 && find_twin(k, twin)) k.protocol = twin;
               else k.protocol = 8'($urandom_range(255, 0));
            end else if (sub >= 65) begin
               k.dest_addr = k.dest_addr ^ (32'h1 << $urandom_range(31, 0));
            end
         end
         send_item(hfw_pkg::OP_LOOKUP, k);
      end
   endtask

   initial begin
      hfw_pkg::key_type zero_key;
      hfw_pkg::key_type ones_key;
      hfw_pkg::key_type dup_key;
      hfw_pkg::key_type wild_key;
      hfw_pkg::key_type probe;
      logic [7:0]       twin;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      idling_on   = 1'b1;
      table_model = new;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      zero_key = '0;
      ones_key = '1;
      send_item(hfw_pkg::OP_CLEAR, zero_key);
      send_item(hfw_pkg::OP_LOOKUP, zero_key);
      send_item(hfw_pkg::OP_INSERT, zero_key);
      send_item(hfw_pkg::OP_INSERT, ones_key);
      send_item(hfw_pkg::OP_LOOKUP, zero_key);
      send_item(hfw_pkg::OP_LOOKUP, ones_key);
      probe          = ones_key;
      probe.protocol = 8'hfe;
      send_item(hfw_pkg::OP_LOOKUP, probe);

      // duplicates fill one bucket; the last insert overflows
      dup_key = {32'hc0a80001, 16'h0050, 8'd6};
      repeat (WAYS + 1) send_item(hfw_pkg::OP_INSERT, dup_key);
      send_item(hfw_pkg::OP_LOOKUP, dup_key);

      // wildcard entry: hit only where the lookup key shares its bucket
      do begin
         wild_key.dest_addr = $urandom;
         wild_key.dest_port = 16'($urandom_range(65535, 0));
         wild_key.protocol  = 8'h00;
      end while (!find_twin(wild_key, twin));
      send_item(hfw_pkg::OP_INSERT, wild_key);
      probe          = wild_key;
      probe.protocol = twin;
      send_item(hfw_pkg::OP_LOOKUP, probe);
      probe.protocol = 8'd17;
      send_item(hfw_pkg::OP_LOOKUP, probe);

      send_item(OP_UNUSED, ones_key);
      send_item(hfw_pkg::OP_CLEAR, ones_key);
      send_item(hfw_pkg::OP_LOOKUP, dup_key);
      send_item(hfw_pkg::OP_LOOKUP, zero_key);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) stall_request = 1'b1;
         if (n == 350) idling_on = 1'b0;
         if (n == 500) idling_on = 1'b1;
         if (n == 550) begin
            req_valid <= 1'b0;
            while (table_model.pending() != 0) @(negedge clock);
            repeat ($urandom_range(40, 10)) @(negedge clock);
         end
         random_item();
      end

      req_valid <= 1'b0;
      while (table_model.pending() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (table_model.errors == 0 && table_model.pending() == 0) begin
         $display("hashed_flow_whitelist regression: pass");
      end else begin
         $display("hashed_flow_whitelist regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/hfw_pkg.sv
hw/rtl/hfw_table.sv
hw/rtl/hashed_flow_whitelist.sv
dv/hashed_flow_whitelist_tb.sv
